FILE: rtl/ray_box_slab_intersect_assert.svh
// Assertion macros shared by the ray-box slab test RTL.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RBSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RBSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rbsi_pkg.sv
// Shared types and constants for the ray-box slab test.
package rbsi_pkg;

  localparam int QW        = 32;
  localparam int DIV_STEPS = QW;
  // load stage + one stage per quotient bit + saturation stage
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int NAXIS     = 3;

  localparam logic signed [QW-1:0] SAT_HI = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] SAT_LO = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] MISS_T = 32'shFFFF0000;

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [2:0] {
    CFG_MIN_X = 3'd0,
    CFG_MIN_Y = 3'd1,
    CFG_MIN_Z = 3'd2,
    CFG_MAX_X = 3'd3,
    CFG_MAX_Y = 3'd4,
    CFG_MAX_Z = 3'd5
  } cfg_idx_t;

  // Per-request data that travels beside the dividers.
  typedef struct packed {
    q_t               t0;
    q_t               t1;
    logic [NAXIS-1:0] dneg;
    logic [NAXIS-1:0] dzero;
    logic [NAXIS-1:0] in_box;
  } side_t;

endpackage

FILE: rtl/rbsi_div_pipe.sv
// Pipelined saturating Q16.16 divider, one quotient bit per stage.
module rbsi_div_pipe (
  input  logic                 clk,
  input  logic                 en,
  input  logic [32:0]          num_abs,
  input  logic [31:0]          den_abs,
  input  logic                 neg,
  output rbsi_pkg::q_t         q
);
  import rbsi_pkg::*;

  logic [QW-1:0] rem_r  [0:DIV_STEPS];
  logic [QW-1:0] den_r  [0:DIV_STEPS];
  logic [QW-1:0] nq_r   [0:DIV_STEPS];
  logic          ovf_r  [0:DIV_STEPS];
  logic          neg_r  [0:DIV_STEPS];
  q_t            q_r;

  // Load: quotient of 2^32 or more saturates; else the top bits start below den.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {15'd0, num_abs[32:16]};
      nq_r[0]  <= {num_abs[15:0], 16'd0};
      den_r[0] <= den_abs;
      ovf_r[0] <= {15'd0, num_abs} >= {den_abs, 16'd0};
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [QW:0] trial;
    logic        take;
    assign trial = {rem_r[k], nq_r[k][QW-1]};
    assign take  = trial >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? QW'(trial - {1'b0, den_r[k]}) : trial[QW-1:0];
        nq_r[k+1]  <= {nq_r[k][QW-2:0], take};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg_r[DIV_STEPS]) begin
        q_r <= (ovf_r[DIV_STEPS] || nq_r[DIV_STEPS][QW-1]) ? SAT_HI : q_t'(nq_r[DIV_STEPS]);
      end else begin
        q_r <= (ovf_r[DIV_STEPS] || nq_r[DIV_STEPS] > 32'h80000000) ? SAT_LO
             : q_t'(-nq_r[DIV_STEPS]);
      end
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/ray_box_slab_intersect.sv
// Top level of the ray versus axis-aligned box slab test.
//
// Usage:
//  - Box corners are six signed Q16.16 registers written over cfg_we /
//    cfg_index / cfg_wdata (min x,y,z then max x,y,z). Write them only while
//    the pipeline is empty; indexes above five are ignored.
//  - Input request: ray origin, direction and the interval t_lower..t_upper,
//    taken when in_valid is high and in_stall is low.
//  - Result request: out_hit and out_t_enter (-1.0 on a miss), taken when
//    out_valid is high and out_stall is low.
//  - Throughput: one ray per cycle unless a result is held under out_stall.
//    Pipeline: the six 32-stage dividers (one quotient bit per stage) with
//    their load and saturation stages, one combine stage and the output
//    register (36 register stages, the first loaded at the accepting edge).
//  - The whole pipeline advances together; when the output register holds a
//    result under out_stall, every stage holds and in_stall rises. Empty
//    stages never block: an idle output register lets everything advance.
//  - Reset (rst_n low, synchronous) clears the box to zero and all valid bits.
module ray_box_slab_intersect (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_ray_origin_x,
  input  logic signed [31:0]   in_ray_origin_y,
  input  logic signed [31:0]   in_ray_origin_z,
  input  logic signed [31:0]   in_ray_dir_x,
  input  logic signed [31:0]   in_ray_dir_y,
  input  logic signed [31:0]   in_ray_dir_z,
  input  logic signed [31:0]   in_t_lower,
  input  logic signed [31:0]   in_t_upper,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic signed [31:0]   out_t_enter
);
  import rbsi_pkg::*;
  `include "ray_box_slab_intersect_assert.svh"

  q_t box_min_r [NAXIS];
  q_t box_max_r [NAXIS];

  // Box registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAXIS; i++) begin
        box_min_r[i] <= '0;
        box_max_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_X: box_min_r[0] <= cfg_wdata;
        CFG_MIN_Y: box_min_r[1] <= cfg_wdata;
        CFG_MIN_Z: box_min_r[2] <= cfg_wdata;
        CFG_MAX_X: box_max_r[0] <= cfg_wdata;
        CFG_MAX_Y: box_max_r[1] <= cfg_wdata;
        CFG_MAX_Z: box_max_r[2] <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  logic out_valid_r;
  logic out_hit_r;
  q_t   out_t_enter_r;

  // Advance every stage unless a finished result is held.
  logic adv;
  logic acc;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  q_t org [NAXIS];
  q_t dir [NAXIS];
  assign org[0] = in_ray_origin_x;
  assign org[1] = in_ray_origin_y;
  assign org[2] = in_ray_origin_z;
  assign dir[0] = in_ray_dir_x;
  assign dir[1] = in_ray_dir_y;
  assign dir[2] = in_ray_dir_z;

  side_t side_in;
  q_t    qa [NAXIS];
  q_t    qb [NAXIS];

  for (genvar a = 0; a < NAXIS; a++) begin : g_axis
    logic signed [32:0] dmn, dmx;
    logic [32:0]        amn, amx;
    logic [31:0]        adir;
    assign dmn  = {box_min_r[a][31], box_min_r[a]} - {org[a][31], org[a]};
    assign dmx  = {box_max_r[a][31], box_max_r[a]} - {org[a][31], org[a]};
    assign amn  = dmn[32] ? 33'(-dmn) : 33'(dmn);
    assign amx  = dmx[32] ? 33'(-dmx) : 33'(dmx);
    assign adir = dir[a][31] ? 32'(-dir[a]) : 32'(dir[a]);

    assign side_in.dneg[a]   = dir[a][31];
    assign side_in.dzero[a]  = (dir[a] == '0);
    assign side_in.in_box[a] = (org[a] >= box_min_r[a]) && (org[a] <= box_max_r[a]);

    rbsi_div_pipe u_div_min (
      .clk     (clk),
      .en      (adv),
      .num_abs (amn),
      .den_abs (adir),
      .neg     (dmn[32] ^ dir[a][31]),
      .q       (qa[a])
    );
    rbsi_div_pipe u_div_max (
      .clk     (clk),
      .en      (adv),
      .num_abs (amx),
      .den_abs (adir),
      .neg     (dmx[32] ^ dir[a][31]),
      .q       (qb[a])
    );
  end

  assign side_in.t0 = in_t_lower;
  assign side_in.t1 = in_t_upper;

  // Side data and valid bits run in step with the dividers.
  side_t side_r [DIV_LAT];
  logic  vld_r  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= acc;
      for (int i = 1; i < DIV_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // Per-axis slab bounds; a zero direction gives an unbounded slab or a miss.
  side_t sd;
  q_t    lo [NAXIS];
  q_t    hi [NAXIS];
  logic  ok [NAXIS];
  assign sd = side_r[DIV_LAT-1];

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      if (sd.dzero[a]) begin
        lo[a] = SAT_LO;
        hi[a] = SAT_HI;
      end else if (sd.dneg[a]) begin
        lo[a] = qb[a];
        hi[a] = qa[a];
      end else begin
        lo[a] = qa[a];
        hi[a] = qb[a];
      end
      ok[a] = !sd.dzero[a] || sd.in_box[a];
    end
  end

  // Combine stage: intersect x with y, carry z along.
  logic c_vld_r;
  logic c_ok_r;
  q_t   c_tmin_r, c_tmax_r, c_lo2_r, c_hi2_r, c_t0_r, c_t1_r;
  logic c_ok2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ok_r   <= ok[0] && ok[1] && !(lo[0] > hi[1] || lo[1] > hi[0]);
      c_tmin_r <= (lo[1] > lo[0]) ? lo[1] : lo[0];
      c_tmax_r <= (hi[1] < hi[0]) ? hi[1] : hi[0];
      c_lo2_r  <= lo[2];
      c_hi2_r  <= hi[2];
      c_ok2_r  <= ok[2];
      c_t0_r   <= sd.t0;
      c_t1_r   <= sd.t1;
    end
  end

  // Output stage: z slab, then the accepted interval.
  q_t   tmin_f, tmax_f;
  logic hit_c;
  assign tmin_f = (c_lo2_r > c_tmin_r) ? c_lo2_r : c_tmin_r;
  assign tmax_f = (c_hi2_r < c_tmax_r) ? c_hi2_r : c_tmax_r;
  assign hit_c  = c_ok_r && c_ok2_r && !(c_tmin_r > c_hi2_r || c_lo2_r > c_tmax_r)
                  && (tmin_f < c_t1_r) && (tmax_f > c_t0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r     <= hit_c;
      out_t_enter_r <= hit_c ? tmin_f : MISS_T;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_t_enter = out_t_enter_r;

  `RBSI_ASSERT_IMP(a_miss_value, out_valid_r && !out_hit_r, out_t_enter_r == MISS_T,
                   "miss result must carry -1.0")
  `RBSI_ASSERT_IMP(a_stall_rule, 1'b1, in_stall == (out_valid_r && out_stall),
                   "input stall must follow a held result only")
  `RBSI_ASSERT_NXT(a_hold_pipe, !adv && vld_r[DIV_LAT-1], vld_r[DIV_LAT-1] && c_vld_r == $past(c_vld_r),
                   "pipeline valid bits must hold under stall")
  `RBSI_ASSERT_NXT(a_out_hold, out_valid_r && out_stall,
                   out_valid_r && $stable(out_t_enter_r) && $stable(out_hit_r),
                   "stalled result must hold")

endmodule

FILE: tb/sv/ray_box_slab_intersect_tb.sv
// Self-checking testbench for the ray versus axis-aligned box slab test.
module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam int LATENCY = 35;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  q_t          in_ray_origin_x = '0, in_ray_origin_y = '0, in_ray_origin_z = '0;
  q_t          in_ray_dir_x = '0, in_ray_dir_y = '0, in_ray_dir_z = '0;
  q_t          in_t_lower = '0, in_t_upper = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_hit;
  q_t          out_t_enter;

  typedef struct {
    q_t org[3];
    q_t dir[3];
    q_t t0;
    q_t t1;
  } ray_t;

  typedef struct {
    logic hit;
    q_t   t_enter;
  } hit_t;

  // Shadow copy of the box registers.
  q_t   box_lo[3];
  q_t   box_hi[3];
  hit_t hits_pending[$];
  int   n_errors = 0;
  bit   quiet = 1'b0;     // no idling on either side when set
  bit   src_idle_en = 1'b1;

  ray_box_slab_intersect DUT (.*);

  always #10 clk = ~clk;

  // Saturating Q16.16 divide, quotient truncated toward zero.
  function automatic q_t slab_div(q_t plane, q_t org, q_t d);
    longint num, quo;
    num = (longint'(plane) - longint'(org)) * 65536;
    quo = num / longint'(d);
    if (quo > longint'(SAT_HI)) return SAT_HI;
    if (quo < longint'(SAT_LO)) return SAT_LO;
    return q_t'(quo);
  endfunction

  function automatic hit_t predict_hit(ray_t r);
    hit_t res;
    q_t   tmin, tmax, lo, hi;
    bit   ok;
    ok = 1'b1;
    tmin = '0;
    tmax = '0;
    for (int a = 0; a < 3 && ok; a++) begin
      if (r.dir[a] == 0) begin
        if (r.org[a] < box_lo[a] || r.org[a] > box_hi[a]) begin
          ok = 1'b0;
          break;
        end
        lo = SAT_LO;
        hi = SAT_HI;
      end else if (r.dir[a] > 0) begin
        lo = slab_div(box_lo[a], r.org[a], r.dir[a]);
        hi = slab_div(box_hi[a], r.org[a], r.dir[a]);
      end else begin
        lo = slab_div(box_hi[a], r.org[a], r.dir[a]);
        hi = slab_div(box_lo[a], r.org[a], r.dir[a]);
      end
      if (a == 0) begin
        tmin = lo;
        tmax = hi;
        continue;
      end
      if (tmin > hi || lo > tmax) begin
        ok = 1'b0;
        break;
      end
      if (lo > tmin) tmin = lo;
      if (hi < tmax) tmax = hi;
    end
    if (ok && !(tmin < r.t1 && tmax > r.t0)) ok = 1'b0;
    res.hit = ok;
    res.t_enter = ok ? tmin : MISS_T;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // Write one box register; only called with the pipeline drained.
  task automatic write_box(cfg_idx_t idx, q_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= CFG_MIN_Z) box_lo[idx] = val;
    else box_hi[idx - CFG_MAX_X] = val;
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_box(q_t lx, q_t ly, q_t lz, q_t hx, q_t hy, q_t hz);
    write_box(CFG_MIN_X, lx);
    write_box(CFG_MIN_Y, ly);
    write_box(CFG_MIN_Z, lz);
    write_box(CFG_MAX_X, hx);
    write_box(CFG_MAX_Y, hy);
    write_box(CFG_MAX_Z, hz);
  endtask

  // Drive one request and hold it until accepted; the valid stays high into
  // the next request when there is no idle burst.
  task automatic send_ray(ray_t r);
    if (!quiet && src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_ray_origin_x <= r.org[0];
    in_ray_origin_y <= r.org[1];
    in_ray_origin_z <= r.org[2];
    in_ray_dir_x    <= r.dir[0];
    in_ray_dir_y    <= r.dir[1];
    in_ray_dir_z    <= r.dir[2];
    in_t_lower      <= r.t0;
    in_t_upper      <= r.t1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hits_pending.push_back(predict_hit(r));
  endtask

  // Drop valid and wait for the pipeline to drain.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hits_pending.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, out_hit}, 32'b0);
      end else begin
        want = hits_pending.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", {31'b0, out_hit}, {31'b0, want.hit});
        if (out_t_enter !== want.t_enter) report_mismatch("t_enter", out_t_enter, want.t_enter);
      end
    end
  end

  // Random result stall bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic q_t rand_q();
    case ($urandom_range(0, 5))
      0: return q_t'($urandom());
      1: return SAT_HI;
      2: return SAT_LO;
      default: return q_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic q_t rand_dir();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return q_t'($urandom());
      2: return q_t'($signed($urandom_range(0, 7)) - 3);
      default: return q_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  function automatic ray_t mk_ray(q_t ox, q_t oy, q_t oz, q_t dx, q_t dy, q_t dz, q_t t0, q_t t1);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.t0 = t0;
    r.t1 = t1;
    return r;
  endfunction

  // Rays aimed at the box with random content; some are pure noise.
  function automatic ray_t rand_ray();
    ray_t r;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 3) == 0) r.org[a] = rand_q();
      else r.org[a] = box_lo[a] + q_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      r.dir[a] = rand_dir();
    end
    r.t0 = ($urandom_range(0, 3) == 0) ? rand_q() : q_t'(-$urandom_range(0, 32'h0001_0000));
    r.t1 = ($urandom_range(0, 3) == 0) ? rand_q() : SAT_HI;
    return r;
  endfunction

  task automatic test_reset_box();
    // Degenerate zero box left by reset.
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(1, 0, 0, 0, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(-32'sh10000, 0, 0, 32'sh10000, 0, 0, SAT_LO, SAT_HI));
    drain();
  endtask

  task automatic test_directed();
    set_box(-32'sh10000, -32'sh10000, -32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000);
    // plain hit along +x, and along -x
    send_ray(mk_ray(-32'sh50000, 0, 0, 32'sh10000, 0, 0, 0, SAT_HI));
    send_ray(mk_ray(32'sh50000, 0, 0, -32'sh10000, 0, 0, 0, SAT_HI));
    // zero direction outside the slab on y and z
    send_ray(mk_ray(-32'sh50000, 32'sh20000, 0, 32'sh10000, 0, 0, 0, SAT_HI));
    send_ray(mk_ray(-32'sh50000, 0, -32'sh20000, 32'sh10000, 0, 0, 0, SAT_HI));
    // zero direction exactly on the boundary plane
    send_ray(mk_ray(-32'sh50000, 32'sh10000, -32'sh10000, 32'sh10000, 0, 0, 0, SAT_HI));
    // touching interval: t_upper equals entry, t_lower equals exit
    send_ray(mk_ray(-32'sh50000, 0, 0, 32'sh10000, 0, 0, 0, 32'sh40000));
    send_ray(mk_ray(-32'sh50000, 0, 0, 32'sh10000, 0, 0, 32'sh60000, SAT_HI));
    // touching slabs on a diagonal, which still count as a hit
    send_ray(mk_ray(-32'sh30000, -32'sh10000, 0, 32'sh10000, 32'sh10000, 0, SAT_LO, SAT_HI));
    // saturating quotients: tiny and extreme directions, extreme origins
    send_ray(mk_ray(SAT_LO, 0, 0, 1, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(SAT_HI, 0, 0, -1, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(SAT_LO, SAT_HI, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_LO, SAT_HI));
    send_ray(mk_ray(0, 0, 0, SAT_HI, SAT_LO, 32'sh10000, SAT_LO, SAT_HI));
    // all zero directions in the box: unbounded everywhere
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, SAT_HI, SAT_LO));
    drain();
    // Inverted box at the range extremes.
    set_box(SAT_HI, SAT_HI, SAT_HI, SAT_LO, SAT_LO, SAT_LO);
    send_ray(mk_ray(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, SAT_LO, SAT_HI));
    send_ray(mk_ray(0, 0, 0, -1, -1, -1, SAT_LO, SAT_HI));
    send_ray(mk_ray(SAT_LO, SAT_HI, 0, 1, -1, 0, SAT_LO, SAT_HI));
    drain();
    set_box(SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI);
    send_ray(mk_ray(SAT_LO, SAT_HI, 0, SAT_HI, SAT_LO, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(SAT_LO, SAT_LO, SAT_LO, 0, 0, 0, SAT_LO, SAT_HI));
    send_ray(mk_ray(123, -456, 789, 1, -1, 32'sh7FFF, SAT_LO, SAT_HI));
    drain();
  endtask

  // Random rays against several random boxes; with no_idle set no phase idles,
  // and the first phase holds off the source once until the pipeline drains.
  task automatic test_random(int phases, int per_phase, bit no_idle);
    q_t lo, hi;
    quiet = no_idle;
    for (int p = 0; p < phases; p++) begin
      for (int a = 0; a < 3; a++) begin
        lo = ($urandom_range(0, 4) == 0) ? rand_q() : q_t'(-$urandom_range(0, 32'h0004_0000));
        hi = ($urandom_range(0, 4) == 0) ? rand_q() : q_t'($urandom_range(0, 32'h0004_0000));
        write_box(cfg_idx_t'(a), lo);
        write_box(cfg_idx_t'(a + 3), hi);
      end
      for (int i = 0; i < per_phase; i++) begin
        // hold the source until every result is back
        if (p == 0 && i == per_phase / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (hits_pending.size() != 0) @(posedge clk);
        end
        send_ray(rand_ray());
      end
      drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_box();
    test_directed();
    test_random(6, 130, 1'b0);
    test_random(1, 150, 1'b1);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && hits_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
